@@ hw/rtl/event_queue_with_storm_guard_defines.svh @@
// assertion macros for the event queue
`ifndef EVENT_QUEUE_WITH_STORM_GUARD_DEFINES_SVH
`define EVENT_QUEUE_WITH_STORM_GUARD_DEFINES_SVH

`ifndef SYNTH

// same-cycle implication, sampled on clk, off while rst is high
`define EQSG_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("event queue check failed");

// next-cycle implication, sampled on clk, off while rst is high
`define EQSG_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("event queue check failed");

`else

`define EQSG_ASSERT_IMPL(label, ante, cons)
`define EQSG_ASSERT_NEXT(label, ante, cons)

`endif

`endif

@@ hw/rtl/eqsg_pkg.sv @@
`timescale 1ns / 1ps

package eqsg_pkg;

  localparam int QUEUE_DEPTH_DEF = 32;

  localparam int FUNC_W     = 2;
  localparam int BYTE_W     = 8;
  localparam int STATUS_W   = 3;
  localparam int OCC_W      = 5;
  localparam int TOTAL_W    = 32;
  localparam int TICK_W     = 8;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;

  // operation codes; the spare code decodes as a tick
  localparam logic [FUNC_W-1:0] FUNC_PUSH = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_POP  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_TICK = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_STORM_THRESHOLD = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_EVENTS_FROZEN   = 1'd1;

  localparam logic [TICK_W-1:0] STORM_THRESHOLD_RST = 8'd8;
  localparam logic [TICK_W-1:0] TICK_MAX            = 8'hFF;

  typedef enum logic [STATUS_W-1:0] {
    ST_PUSHED = 3'd0,
    ST_FROZEN = 3'd1,
    ST_STORM  = 3'd2,
    ST_FULL   = 3'd3,
    ST_POPPED = 3'd4,
    ST_EMPTY  = 3'd5,
    ST_TICK   = 3'd6
  } status_t;

endpackage

@@ hw/rtl/eqsg_cmd_if.sv @@
`timescale 1ns / 1ps

interface eqsg_cmd_if;
  import eqsg_pkg::*;

  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [BYTE_W-1:0] event_byte;

  modport source (output valid, output func, output event_byte, input ready);
  modport sink   (input valid, input func, input event_byte, output ready);
endinterface

@@ hw/rtl/eqsg_result_if.sv @@
`timescale 1ns / 1ps

interface eqsg_result_if;
  import eqsg_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [BYTE_W-1:0]   popped_byte;
  logic [OCC_W-1:0]    occupancy;
  logic [TOTAL_W-1:0]  dropped_total;
  logic [TOTAL_W-1:0]  storm_total;
  logic [TOTAL_W-1:0]  popped_total;

  modport source (
    output valid, output status, output popped_byte, output occupancy,
    output dropped_total, output storm_total, output popped_total,
    input ready
  );
  modport sink (
    input valid, input status, input popped_byte, input occupancy,
    input dropped_total, input storm_total, input popped_total,
    output ready
  );
endinterface

@@ hw/rtl/event_queue_with_storm_guard.sv @@
`timescale 1ns / 1ps
`include "event_queue_with_storm_guard_defines.svh"

// Byte event queue with a per-tick storm guard. Each cmd beat is a push, a pop
// or a tick (the spare func code acts as a tick) and yields exactly one result
// beat carrying a status, the popped byte (zero unless popped), the occupancy
// after the operation and three wrapping 32-bit totals. The ring holds at most
// QUEUE_DEPTH-1 events. A push is dropped when events_frozen is set, when the
// per-tick push count (raised first, saturating at 255) exceeds
// storm_threshold, or when the ring is full. Rate: one cmd beat per clock;
// its result is valid on the following cycle, from the result register and,
// for a pop, the registered read port of the ring memory. While a result
// beat is not taken, cmd.ready stays low. Configuration writes land on the
// edge where cfg_we is high and are meant for idle periods only. No clearing
// pass after reset: the ring is never read at an entry that was not written.
module event_queue_with_storm_guard #(
  parameter int QUEUE_DEPTH = eqsg_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [eqsg_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [eqsg_pkg::CFG_DATA_W-1:0]  cfg_data,
  eqsg_cmd_if.sink                         cmd,
  eqsg_result_if.source                    result
);
  import eqsg_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(QUEUE_DEPTH - 1);

  // ring pointers and per-tick count
  logic [PTR_W-1:0]   write_slot;
  logic [PTR_W-1:0]   read_slot;
  logic [TICK_W-1:0]  tick_pushes;
  // running totals; they change only on an accepted beat, so they also serve
  // as the payload of the pending result
  logic [TOTAL_W-1:0] drop_counter;
  logic [TOTAL_W-1:0] storm_counter;
  logic [TOTAL_W-1:0] pop_counter;
  // configuration
  logic [TICK_W-1:0]  storm_threshold;
  logic               events_frozen;
  // result register
  logic               res_valid;
  status_t            res_status;

  logic               cmd_fire;
  logic [PTR_W-1:0]   write_adv;
  logic [PTR_W-1:0]   read_adv;
  logic               ring_full;
  logic               ring_empty;
  logic [TICK_W-1:0]  tick_inc;

  logic [PTR_W-1:0]   write_slot_next;
  logic [PTR_W-1:0]   read_slot_next;
  logic [TICK_W-1:0]  tick_pushes_next;
  status_t            res_status_next;
  logic               drop_inc;
  logic               storm_inc;
  logic               pop_inc;
  logic               ram_we;
  logic               ram_re;
  logic [BYTE_W-1:0]  ram_rdata;
  logic [PTR_W:0]     occ_diff;

  // a new beat enters when the result register is free or being emptied
  assign cmd.ready = !res_valid || result.ready;
  assign cmd_fire  = cmd.valid && cmd.ready;

  assign write_adv  = (write_slot == LAST_SLOT) ? '0 : write_slot + 1'b1;
  assign read_adv   = (read_slot == LAST_SLOT) ? '0 : read_slot + 1'b1;
  assign ring_full  = (write_adv == read_slot);
  assign ring_empty = (write_slot == read_slot);
  // count is raised before the storm compare, saturating
  assign tick_inc   = (tick_pushes == TICK_MAX) ? tick_pushes : tick_pushes + 1'b1;

  always_comb begin
    write_slot_next  = write_slot;
    read_slot_next   = read_slot;
    tick_pushes_next = tick_pushes;
    res_status_next  = ST_TICK;
    drop_inc         = 1'b0;
    storm_inc        = 1'b0;
    pop_inc          = 1'b0;
    ram_we           = 1'b0;
    ram_re           = 1'b0;
    case (cmd.func)
      FUNC_PUSH: begin
        if (events_frozen) begin
          // frozen drop does not count toward the tick
          res_status_next = ST_FROZEN;
          drop_inc        = 1'b1;
        end else begin
          tick_pushes_next = tick_inc;
          if (tick_inc > storm_threshold) begin
            res_status_next = ST_STORM;
            drop_inc        = 1'b1;
            storm_inc       = 1'b1;
          end else if (ring_full) begin
            res_status_next = ST_FULL;
            drop_inc        = 1'b1;
          end else begin
            res_status_next = ST_PUSHED;
            ram_we          = 1'b1;
            write_slot_next = write_adv;
          end
        end
      end
      FUNC_POP: begin
        if (ring_empty) begin
          res_status_next = ST_EMPTY;
        end else begin
          // oldest byte comes out of the ram on the next cycle
          res_status_next = ST_POPPED;
          ram_re          = 1'b1;
          pop_inc         = 1'b1;
          read_slot_next  = read_adv;
        end
      end
      default: begin
        // tick, and the spare code that decodes as one
        tick_pushes_next = '0;
        res_status_next  = ST_TICK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      write_slot      <= '0;
      read_slot       <= '0;
      tick_pushes     <= '0;
      drop_counter    <= '0;
      storm_counter   <= '0;
      pop_counter     <= '0;
      storm_threshold <= STORM_THRESHOLD_RST;
      events_frozen   <= 1'b0;
      res_valid       <= 1'b0;
      res_status      <= ST_TICK;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_STORM_THRESHOLD: storm_threshold <= cfg_data;
          CFG_EVENTS_FROZEN:   events_frozen   <= cfg_data[0];
          default: ;
        endcase
      end
      if (result.ready) begin
        res_valid <= 1'b0;
      end
      if (cmd_fire) begin
        res_valid     <= 1'b1;
        res_status    <= res_status_next;
        write_slot    <= write_slot_next;
        read_slot     <= read_slot_next;
        tick_pushes   <= tick_pushes_next;
        drop_counter  <= drop_counter + TOTAL_W'(drop_inc);
        storm_counter <= storm_counter + TOTAL_W'(storm_inc);
        pop_counter   <= pop_counter + TOTAL_W'(pop_inc);
      end
    end
  end

  // event ring: written on an accepted push, read on an accepted pop
  eqsg_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (cmd_fire && ram_we),
    .waddr (write_slot),
    .wdata (cmd.event_byte),
    .re    (cmd_fire && ram_re),
    .raddr (read_slot),
    .rdata (ram_rdata)
  );

  // occupancy from the pointers as they stand after the last beat
  always_comb begin
    occ_diff = {1'b0, write_slot} - {1'b0, read_slot};
    if (write_slot < read_slot) begin
      occ_diff = occ_diff + (PTR_W + 1)'(QUEUE_DEPTH);
    end
  end

  assign result.valid         = res_valid;
  assign result.status        = res_status;
  assign result.popped_byte   = (res_status == ST_POPPED) ? ram_rdata : '0;
  assign result.occupancy     = OCC_W'(occ_diff);
  assign result.dropped_total = drop_counter;
  assign result.storm_total   = storm_counter;
  assign result.popped_total  = pop_counter;

  // pointers stay inside the ring, also for depths that are not a power of two
  `EQSG_ASSERT_IMPL(a_slot_range, 1'b1, write_slot <= LAST_SLOT && read_slot <= LAST_SLOT)
  // every storm drop is also counted as a drop
  `EQSG_ASSERT_IMPL(a_storm_is_drop, !$past(rst) && $changed(storm_counter), $changed(drop_counter))
  // an accepted pop of a non-empty ring raises the pop total by one
  `EQSG_ASSERT_NEXT(a_pop_count, cmd_fire && pop_inc, pop_counter == $past(pop_counter) + 1'b1)

endmodule

@@ hw/rtl/eqsg_ram.sv @@
`timescale 1ns / 1ps

module eqsg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read data holds until the next read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
